[hdl/sps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the scaled periodic sine generator.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Default widths
  localparam int DW_DEFAULT  = 32;
  localparam int SFB_DEFAULT = 16;
  localparam int MAX_DW      = 48;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd2;

  // Register reset values
  localparam logic [30:0] PERIOD_RST    = 31'd131072;
  localparam logic [31:0] OFFSET_RST    = 32'd0;
  localparam logic [31:0] AMPLITUDE_RST = 32'd65536;

  // Queue between front and back
  localparam int QDEPTH = 4;

  // Fixed point constants: one in Q1.30 and pi/2 in Q1.30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] HALF_PI = 31'd1686629713;

  // Horner divisors and their floor(2^32 / d) reciprocals
  localparam int HORNER_N = 6;
  localparam logic [7:0]  HDIV  [HORNER_N] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] RECIP [HORNER_N] = '{30'd27531841, 30'd39045157, 30'd59652323,
                                               30'd102261126, 30'd214748364, 30'd715827882};

  // Beat passed from front to back: sign and magnitude of (position - offset)
  typedef struct packed {
    logic        dneg;
    logic [32:0] num;
  } sps_item_t;

  // Working set of one back-end pipeline stage
  typedef struct packed {
    logic              dneg;
    logic [32:0]       num;
    logic [30:0]       rem;
    logic [31:0]       quo;
    logic [1:0]        quad;
    logic [30:0]       t;
    logic [31:0]       t2;
    logic [30:0]       v;
    logic [32:0]       x;
    logic [63:0]       m;
    logic [MAX_DW-1:0] res;
    logic              sat;
  } sps_stage_t;

endpackage

[hdl/sps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_front
// Accepts positions, forms position - offset and splits it into sign and
// magnitude for the back end.
// ----------------------------------------------------------------------------
module sps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_position,
  input  logic [31:0]         phase_offset,
  output logic                push,
  output sps_pkg::sps_item_t  push_item,
  input  logic                q_ready
);
  import sps_pkg::*;

  logic        fv_r;
  sps_item_t   fitem_r;
  logic [32:0] diff;
  sps_item_t   item_nxt;

  // Difference at 33 bits, then sign and magnitude
  always_comb begin
    diff          = {in_position[31], in_position} - {phase_offset[31], phase_offset};
    item_nxt.dneg = diff[32];
    item_nxt.num  = diff[32] ? (33'd0 - diff) : diff;
  end

  assign in_ready  = !fv_r || q_ready;
  assign push      = fv_r && q_ready;
  assign push_item = fitem_r;

  // Hold the beat until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fitem_r <= item_nxt;
    end
  end

endmodule

[hdl/sps_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_fifo
// Short queue that decouples the front end from the back-end pipeline.
// ----------------------------------------------------------------------------
module sps_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sps_pkg::sps_item_t push_item,
  output logic               wr_ready,
  input  logic               pop,
  output sps_pkg::sps_item_t head,
  output logic               rd_valid
);
  import sps_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  sps_item_t         mem_r [QDEPTH];
  logic [PW-1:0]     wp_r;
  logic [PW-1:0]     rp_r;
  logic [PW:0]       cnt_r;

  assign wr_ready = (cnt_r != (PW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign head     = mem_r[rp_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QDEPTH)) else $error("queue count overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop from empty queue");

endmodule

[hdl/sps_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_back
// Fully pipelined datapath: modulo by period, phase division, quadrant
// folding, Taylor sine in Horner form, amplitude scaling and saturation.
// ----------------------------------------------------------------------------
module sps_back #(
  parameter int DATA_WIDTH     = sps_pkg::DW_DEFAULT,
  parameter int SINE_FRAC_BITS = sps_pkg::SFB_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  sps_pkg::sps_item_t    item,
  output logic                  item_ready,
  input  logic [30:0]           period,
  input  logic [31:0]           amplitude,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_wave_value,
  output logic                  out_saturated
);
  import sps_pkg::*;

  // Stage map
  localparam int MOD_N = 33;
  localparam int FIX_S = MOD_N;
  localparam int DIV_S = FIX_S + 1;
  localparam int MIR_S = DIV_S + 32;
  localparam int TM_S  = MIR_S + 1;
  localparam int T2_S  = TM_S + 1;
  localparam int HOR_S = T2_S + 1;
  localparam int S_S   = HOR_S + 3 * HORNER_N;
  localparam int SF_S  = S_S + 1;
  localparam int AM_S  = SF_S + 1;
  localparam int FIN_S = AM_S + 1;
  localparam int NST   = FIN_S + 1;

  localparam logic [32:0] SF_HALF  = 33'(1) << (29 - SINE_FRAC_BITS);
  localparam logic [63:0] FIN_HALF = 64'(1) << (SINE_FRAC_BITS - 1);
  localparam logic [63:0] MAX_MAG  = (64'(1) << (DATA_WIDTH - 1)) - 64'(1);
  localparam logic [63:0] MIN_MAG  = 64'(1) << (DATA_WIDTH - 1);

  logic [NST-1:0] vld_r;
  sps_stage_t     sq_r  [NST];
  sps_stage_t     nxt   [NST];
  logic           en;
  logic [31:0]    amag;

  assign en         = !vld_r[NST-1] || out_ready;
  assign item_ready = en;
  assign amag       = amplitude[31] ? (32'd0 - amplitude) : amplitude;

  // Next value of every stage
  always_comb begin
    sps_stage_t  cur;
    sps_stage_t  nx;
    logic [30:0] rem_in;
    logic [31:0] trial;
    logic [30:0] qf;
    logic [61:0] p62;
    logic [62:0] p63;
    logic [32:0] q0;
    logic [32:0] rm;
    logic [32:0] qv;
    logic [63:0] mag;
    for (int k = 0; k < NST; k++) begin
      rem_in = '0;
      trial  = '0;
      qf     = '0;
      p62    = '0;
      p63    = '0;
      q0     = '0;
      rm     = '0;
      qv     = '0;
      mag    = '0;
      if (k == 0) begin
        cur      = '0;
        cur.dneg = item.dneg;
        cur.num  = item.num;
      end else begin
        cur = sq_r[k-1];
      end
      nx = cur;
      if (k < MOD_N) begin
        // Remainder by period, one dividend bit a stage
        rem_in = (k == 0) ? 31'd0 : cur.rem;
        trial  = {rem_in, cur.num[MOD_N-1-k]};
        if (trial >= {1'b0, period}) begin
          nx.rem = 31'(trial - {1'b0, period});
        end else begin
          nx.rem = trial[30:0];
        end
      end else if (k == FIX_S) begin
        // Bring a negative remainder into [0, period)
        if (cur.dneg && (cur.rem != '0)) begin
          nx.rem = period - cur.rem;
        end
      end else if (k >= DIV_S && k < DIV_S + 32) begin
        // Phase quotient r * 2^32 / period, one bit a stage
        trial = {cur.rem, 1'b0};
        if (trial >= {1'b0, period}) begin
          nx.rem = 31'(trial - {1'b0, period});
          nx.quo[5'(31 - (k - DIV_S))] = 1'b1;
        end else begin
          nx.rem = trial[30:0];
          nx.quo[5'(31 - (k - DIV_S))] = 1'b0;
        end
      end else if (k == MIR_S) begin
        // Pick quadrant and mirror odd quadrants
        nx.quad = cur.quo[31:30];
        qf      = {1'b0, cur.quo[29:0]};
        nx.t    = cur.quo[30] ? (Q30_ONE - qf) : qf;
      end else if (k == TM_S) begin
        p62  = 62'(cur.t) * 62'(HALF_PI);
        nx.t = 31'(p62 >> 30);
      end else if (k == T2_S) begin
        p62   = 62'(cur.t) * 62'(cur.t);
        nx.t2 = 32'(p62 >> 30);
        nx.v  = Q30_ONE;
      end else if (k >= HOR_S && k < S_S) begin
        // Horner step: product, reciprocal multiply, correct and subtract
        for (int h = 0; h < HORNER_N; h++) begin
          if (k == HOR_S + 3 * h) begin
            p63  = 63'(cur.t2) * 63'(cur.v);
            nx.x = 33'(p63 >> 30);
          end else if (k == HOR_S + 3 * h + 1) begin
            nx.m = 64'(cur.x) * 64'(RECIP[h]);
          end else if (k == HOR_S + 3 * h + 2) begin
            q0   = 33'(cur.m >> 32);
            rm   = cur.x - 33'(q0 * 33'(HDIV[h]));
            qv   = (rm >= 33'(HDIV[h])) ? (q0 + 33'd1) : q0;
            nx.v = 31'(33'(Q30_ONE) - qv);
          end
        end
      end else if (k == S_S) begin
        p62  = 62'(cur.t) * 62'(cur.v);
        nx.x = 33'(p62 >> 30);
      end else if (k == SF_S) begin
        nx.x = (cur.x + SF_HALF) >> (30 - SINE_FRAC_BITS);
      end else if (k == AM_S) begin
        nx.m    = 64'(amag) * 64'(cur.x);
        nx.dneg = cur.quad[1] ^ amplitude[31];
      end else begin
        // Round half away from zero, sign and saturate
        mag = (cur.m + FIN_HALF) >> SINE_FRAC_BITS;
        if (!cur.dneg && (mag > MAX_MAG)) begin
          nx.res = MAX_DW'(MAX_MAG);
          nx.sat = 1'b1;
        end else if (cur.dneg && (mag > MIN_MAG)) begin
          nx.res = MAX_DW'(64'd0 - MIN_MAG);
          nx.sat = 1'b1;
        end else begin
          nx.res = cur.dneg ? MAX_DW'(64'd0 - mag) : MAX_DW'(mag);
          nx.sat = 1'b0;
        end
      end
      nxt[k] = nx;
    end
  end

  // Advance the whole pipe unless the output beat is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        sq_r[k] <= nxt[k];
      end
    end
  end

  assign out_valid      = vld_r[NST-1];
  assign out_wave_value = sq_r[NST-1].res[DATA_WIDTH-1:0];
  assign out_saturated  = sq_r[NST-1].sat;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(vld_r))
    else $error("pipeline moved during stall");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_wave_value == DATA_WIDTH'(MAX_MAG)) || (out_wave_value == DATA_WIDTH'(MIN_MAG)))
    else $error("saturated beat not at a rail");

endmodule

[hdl/scaled_periodic_sine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_periodic_sine
// Returns amplitude * sin(2*pi*(position - offset)/period) in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready/in_position carries one Q16.16 position
//    per beat; output channel out_valid/out_ready carries out_wave_value and
//    out_saturated, one result beat for each input beat, in order.
//  - Throughput: one beat per cycle sustained while out_ready is high. Each
//    beat passes one front register, the queue and a 91-stage back pipe:
//    33 remainder stages, 32 phase division stages, 18 Horner stages and the
//    fixup, fold, multiply, scaling and rounding stages.
//  - The configuration port (cfg_we, cfg_index, cfg_wdata) writes period,
//    phase offset and amplitude; write only while idle. A zero
//    period is ignored; indexes beyond amplitude do nothing.
//  - Reset (synchronous, rst_n low) empties the pipe and the queue and
//    restores period 2.0, offset 0 and amplitude 1.0.
//  - When out_ready is low with a result waiting, the back pipe freezes; the
//    four-entry queue and the front register keep taking beats until they fill.
// ----------------------------------------------------------------------------
module scaled_periodic_sine #(
  parameter int DATA_WIDTH     = sps_pkg::DW_DEFAULT,
  parameter int SINE_FRAC_BITS = sps_pkg::SFB_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    in_position,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [DATA_WIDTH-1:0]          out_wave_value,
  output logic                           out_saturated,
  input  logic                           cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import sps_pkg::*;

  logic [30:0] period_r;
  logic [31:0] offset_r;
  logic [31:0] amplitude_r;

  logic        push;
  sps_item_t   push_item;
  logic        q_ready;
  logic        pop;
  sps_item_t   head;
  logic        rd_valid;
  logic        item_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      offset_r    <= OFFSET_RST;
      amplitude_r <= AMPLITUDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIOD: begin
          if (cfg_wdata[30:0] != '0) begin
            period_r <= cfg_wdata[30:0];
          end
        end
        REG_OFFSET:    offset_r    <= cfg_wdata;
        REG_AMPLITUDE: amplitude_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_position  (in_position),
    .phase_offset (offset_r),
    .push         (push),
    .push_item    (push_item),
    .q_ready      (q_ready)
  );

  sps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .wr_ready  (q_ready),
    .pop       (pop),
    .head      (head),
    .rd_valid  (rd_valid)
  );

  assign pop = rd_valid && item_ready;

  sps_back #(
    .DATA_WIDTH     (DATA_WIDTH),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (rd_valid),
    .item           (head),
    .item_ready     (item_ready),
    .period         (period_r),
    .amplitude      (amplitude_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_wave_value (out_wave_value),
    .out_saturated  (out_saturated)
  );

endmodule

[tb/scaled_periodic_sine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_periodic_sine_test
// Self-checking bench for the scaled periodic sine generator. A fixed point
// predictor computes each expected wave value and clip flag; results are
// checked in order while both channels idle in random bursts.
// ----------------------------------------------------------------------------
module scaled_periodic_sine_test;
  import sps_pkg::*;

  localparam int LATENCY   = 92;
  localparam int LIMIT     = 400000;
  localparam int N_RANDOM  = 1600;

  typedef struct {
    logic [31:0] wave;
    logic        sat;
  } wave_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: predictor with its own copy of the registers
  // --------------------------------------------------------------------------
  class sine_board;
    logic [30:0] cycle_len;
    logic signed [31:0] start_x;
    logic signed [31:0] height;
    wave_t pending[$];

    function void clear();
      cycle_len = PERIOD_RST;
      start_x   = OFFSET_RST;
      height    = AMPLITUDE_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_PERIOD:    if (val[30:0] != 0) cycle_len = val[30:0];
        REG_OFFSET:    start_x = val;
        REG_AMPLITUDE: height = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] quarter(logic [63:0] qf);
      logic [63:0] t, t2, v;
      logic [63:0] divs[6];
      divs = '{156, 110, 72, 42, 20, 6};
      t  = (qf * 64'd1686629713) >> 30;
      t2 = (t * t) >> 30;
      v  = 64'd1 << 30;
      for (int i = 0; i < 6; i++)
        v = (64'd1 << 30) - ((t2 * v) >> 30) / divs[i];
      return (t * v) >> 30;
    endfunction

    function wave_t predict(logic signed [31:0] x);
      longint d, rs, mag, res;
      logic [63:0] r, ph, qf, sf, amag;
      logic [1:0] quad;
      bit neg;
      wave_t w;
      d  = longint'(x) - longint'(start_x);
      rs = d % longint'(cycle_len);
      if (rs < 0) rs += longint'(cycle_len);
      r  = rs;
      ph = (r << 32) / {33'd0, cycle_len};
      quad = ph[31:30];
      qf = {34'd0, ph[29:0]};
      if (quad[0]) qf = (64'd1 << 30) - qf;
      sf = (quarter(qf) + (64'd1 << 13)) >> 14;
      neg = quad[1];
      if (height < 0) begin
        amag = -longint'(height);
        neg = !neg;
      end else begin
        amag = longint'(height);
      end
      mag = (amag * sf + 64'd32768) >> 16;
      res = neg ? -mag : mag;
      w.sat = 0;
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        w.sat = 1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        w.sat = 1;
      end
      w.wave = res[31:0];
      return w;
    endfunction

    function void note_position(logic [31:0] x);
      pending.push_back(predict(x));
    endfunction

    task check_result(logic [31:0] wave, logic sat);
      wave_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", wave));
        return;
      end
      e = pending.pop_front();
      if (wave !== e.wave)
        report($sformatf("wave_value %h, predicted %h", wave, e.wave));
      if (sat !== e.sat)
        report($sformatf("saturated %b, predicted %b", sat, e.sat));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [31:0] in_position = 0;
  logic out_valid, out_ready = 0;
  logic [31:0] out_wave_value;
  logic out_saturated;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  sine_board board = new();
  int cycles = 0;
  bit calm = 0;        // no idling in the last part
  int hold_off = 0;    // long receiver stall, counted below
  int sent = 0, got = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  scaled_periodic_sine uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_position(in_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_wave_value(out_wave_value), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Count cycles and end a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_wave_value, out_saturated);
      got++;
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // Send one position beat, with an optional idle burst ahead of it
  task automatic send_position(input logic [31:0] x);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    in_position <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_position(x);
    sent++;
  endtask

  // Drop valid, wait for the pipe to drain, then the latency margin
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return $urandom_range(0, 8) << 16;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] per;
    board.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset settings, boundaries, quadrant peaks, field extremes
    send_position(32'h0000_0000);
    send_position(32'h0002_0000);
    send_position(32'h0000_8000);
    send_position(32'h0001_8000);
    send_position(32'h7fff_ffff);
    send_position(32'h8000_0000);
    send_position(32'hffff_ffff);
    drain();
    // Zero period is ignored; index beyond amplitude does nothing
    write_cfg(REG_PERIOD, 32'h0);
    write_cfg(2'd3, 32'hdead_beef);
    send_position(32'h0000_8000);
    drain();
    // Full negative amplitude at sine -1 clips
    write_cfg(REG_AMPLITUDE, 32'h8000_0000);
    send_position(32'h0001_8000);
    send_position(32'h0000_8000);
    drain();
    write_cfg(REG_AMPLITUDE, 32'h7fff_ffff);
    write_cfg(REG_PERIOD, 32'h7fff_ffff);
    write_cfg(REG_OFFSET, 32'h8000_0000);
    send_position(32'h7fff_ffff);
    send_position(32'h8000_0000);
    send_position(32'h0000_0000);
    drain();
    write_cfg(REG_PERIOD, 32'h1);
    write_cfg(REG_OFFSET, 32'h7fff_ffff);
    send_position(32'h1234_5678);
    send_position(32'h8000_0000);
    drain();

    // Random phases, each with new settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: per = $urandom_range(1, 16);
        1: per = $urandom_range(1, 8) << 16;
        2: per = $urandom;
        default: per = 32'h7fff_ffff;
      endcase
      write_cfg(REG_PERIOD, per);
      write_cfg(REG_OFFSET, (ph == 7) ? 32'h8000_0000 : $urandom);
      write_cfg(REG_AMPLITUDE, (ph % 3 == 0) ? $urandom
                : ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff));
      if (ph == 6) calm = 1;
      if (ph == 2) hold_off = 300;
      for (int i = 0; i < N_RANDOM / 8; i++)
        send_position(rand_pos());
      // Pause until every result has come
      drain();
    end

    $display("sent %0d positions and checked %0d results over 8 random settings", sent, got);
    $display("directed cases: cycle boundaries, zero period, clipping, extremes");
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
hdl/sps_pkg.sv
hdl/sps_front.sv
hdl/sps_fifo.sv
hdl/sps_back.sv
hdl/scaled_periodic_sine.sv
tb/scaled_periodic_sine_test.sv
